@@ rtl/assert_macros.svh @@
// Assertion macros for the design file that checks itself (next_permutation_engine_top).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on the block clock, off during reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication on the block clock, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/npe_pkg.sv @@
// Shared constants, command codes and interface structs of the permutation engine.
package npe_pkg;

   // store geometry
   localparam int MAX_ITEMS = 32;
   localparam int KEY_WIDTH = 8;
   localparam int ADDR_W    = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

   // fixed field widths of the words
   localparam int CMD_W     = 2;
   localparam int INDEX_W   = 5;
   localparam int KEY_IN_W  = 8;
   localparam int KEY_OUT_W = 8;
   localparam int CFG_W     = 6;

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [INDEX_W-1:0]  index;
      logic [KEY_IN_W-1:0] key_in;
   } cmd_type;

   typedef struct packed {
      logic                 rd_en;
      logic [ADDR_W-1:0]    rd_addr;
      logic                 wr_en;
      logic [ADDR_W-1:0]    wr_addr;
      logic [KEY_WIDTH-1:0] wr_data;
   } mem_req_type;

   typedef struct packed {
      logic                 valid;
      logic [KEY_OUT_W-1:0] key_out;
      logic                 was_last;
   } result_type;

endpackage

@@ rtl/next_permutation_engine_top.sv @@
// Next-permutation engine top: stream ports, item count register, key RAM, result word.
// An advance runs a right-to-left ascent scan and a successor scan, one RAM read a
// cycle each, then a suffix reversal through the single write port.
// One word in work at a time; the next is taken while a result waits in the output word.
// Synchronous active-high reset clears control and item_count; the key RAM is not cleared.
`include "assert_macros.svh"

module next_permutation_engine_top
   import npe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // configuration
   input  logic             csr_we,
   input  logic [CFG_W-1:0] csr_wdata,   // item_count
   // command words
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [15:0]      req_tdata,   // index[4:0], key_in[12:5], zero pad
   input  logic [1:0]       req_tuser,   // command[1:0]
   // result words
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // key_out[7:0]
   output logic             rsp_tlast    // was_last
);

   logic [CFG_W-1:0]     item_count_ff;
   logic [CNT_W-1:0]     count;
   cmd_type              cmd;
   logic                 start;
   logic                 seq_idle;
   logic                 res_ready;
   mem_req_type          mem;
   result_type           res;
   logic [KEY_WIDTH-1:0] rd_data;

   logic                 rsp_valid_ff;
   logic [KEY_OUT_W-1:0] rsp_key_ff;
   logic                 rsp_last_ff;

   // item count register; the count in use is saturated to the store size
   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= '0;
      end else if (csr_we) begin
         item_count_ff <= csr_wdata;
      end
   end

   assign count = (32'(item_count_ff) > MAX_ITEMS) ? CNT_W'(MAX_ITEMS)
                                                   : CNT_W'(item_count_ff);

   // unpack the command word
   assign cmd.command = req_tuser[CMD_W-1:0];
   assign cmd.index   = req_tdata[INDEX_W-1:0];
   assign cmd.key_in  = req_tdata[INDEX_W+KEY_IN_W-1:INDEX_W];

   assign req_tready = seq_idle;
   assign start      = req_tvalid && req_tready;
   assign res_ready  = !rsp_valid_ff || rsp_tready;

   npe_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (cmd),
      .count     (count),
      .res_ready (res_ready),
      .rd_data   (rd_data),
      .idle      (seq_idle),
      .mem       (mem),
      .res       (res)
   );

   npe_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (MAX_ITEMS)
   ) u_keys (
      .clock   (clock),
      .wr_en   (mem.wr_en),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.wr_data),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (rd_data)
   );

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res.valid;
      end
      if (res_ready && res.valid) begin
         rsp_key_ff  <= res.key_out;
         rsp_last_ff <= res.was_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_key_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `ASSERT_NEXT(a_busy_after_accept, start, !req_tready, "ready stayed high after accept")
   `ASSERT_IMPLIES(a_walk_in_range, mem.wr_en && !start, CNT_W'(mem.wr_addr) < count, "advance wrote outside the active items")
   `ASSERT_IMPLIES(a_no_rw_collide, mem.wr_en && mem.rd_en, mem.wr_addr != mem.rd_addr, "RAM read and write hit one entry")
   `ASSERT_NEXT(a_result_held, res.valid && !res_ready, res.valid && $stable(res.key_out) && $stable(res.was_last), "pending result changed")

endmodule

@@ rtl/npe_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
module npe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/npe_seq.sv @@
// Command sequencer: load, read and the next-permutation walk over the key RAM.
module npe_seq
   import npe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  cmd_type              cmd,
   input  logic [CNT_W-1:0]     count,
   input  logic                 res_ready,
   input  logic [KEY_WIDTH-1:0] rd_data,
   output logic                 idle,
   output mem_req_type          mem,
   output result_type           res
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_SCAN,
      ST_FIND,
      ST_SWAP,
      ST_REV_LO,
      ST_REV_HI,
      ST_REV_WLO,
      ST_REV_WHI,
      ST_RESULT
   } state_type;

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    ptr_ff, ptr_in;
   logic [ADDR_W-1:0]    piv_pos_ff, piv_pos_in;
   logic [KEY_WIDTH-1:0] pivot_ff, pivot_in;
   logic [KEY_WIDTH-1:0] prev_ff, prev_in;
   logic                 first_ff, first_in;
   logic [ADDR_W-1:0]    lo_ff, lo_in;
   logic [ADDR_W-1:0]    hi_ff, hi_in;
   logic [KEY_WIDTH-1:0] hold_ff, hold_in;
   logic [KEY_OUT_W-1:0] res_key_ff, res_key_in;
   logic                 res_last_ff, res_last_in;

   logic [ADDR_W-1:0] last_pos;
   logic              idx_ok;

   assign last_pos = ADDR_W'(count - CNT_W'(1));
   assign idx_ok   = (32'(cmd.index) < MAX_ITEMS);

   // next state and RAM port control
   always_comb begin
      state_in    = state_ff;
      ptr_in      = ptr_ff;
      piv_pos_in  = piv_pos_ff;
      pivot_in    = pivot_ff;
      prev_in     = prev_ff;
      first_in    = first_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      hold_in     = hold_ff;
      res_key_in  = res_key_ff;
      res_last_in = res_last_ff;
      mem         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               res_key_in  = '0;
               res_last_in = 1'b0;
               state_in    = ST_RESULT;
               unique case (cmd.command)
                  CMD_LOAD: begin
                     mem.wr_en   = idx_ok;
                     mem.wr_addr = ADDR_W'(cmd.index);
                     mem.wr_data = KEY_WIDTH'(cmd.key_in);
                  end
                  CMD_READ: begin
                     if (idx_ok) begin
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = ADDR_W'(cmd.index);
                        state_in    = ST_RD_WAIT;
                     end
                  end
                  CMD_ADVANCE: begin
                     if (count < CNT_W'(2)) begin
                        res_last_in = 1'b1;
                     end else begin
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = last_pos;
                        ptr_in      = last_pos;
                        first_in    = 1'b1;
                        state_in    = ST_SCAN;
                     end
                  end
                  default: begin
                     // unused code: zero result
                  end
               endcase
            end
         end

         ST_RD_WAIT: begin
            res_key_in = KEY_OUT_W'(rd_data);
            state_in   = ST_RESULT;
         end

         // walk right to left for the rightmost ascent
         ST_SCAN: begin
            if (!first_ff && (rd_data < prev_ff)) begin
               piv_pos_in  = ptr_ff;
               pivot_in    = rd_data;
               mem.rd_en   = 1'b1;
               mem.rd_addr = last_pos;
               ptr_in      = last_pos;
               state_in    = ST_FIND;
            end else if (ptr_ff == '0) begin
               res_last_in = 1'b1;
               state_in    = ST_RESULT;
            end else begin
               prev_in     = rd_data;
               first_in    = 1'b0;
               mem.rd_en   = 1'b1;
               mem.rd_addr = ptr_ff - ADDR_W'(1);
               ptr_in      = ptr_ff - ADDR_W'(1);
            end
         end

         // rightmost key above the pivot; the suffix is non-increasing
         ST_FIND: begin
            if (rd_data > pivot_ff) begin
               mem.wr_en   = 1'b1;
               mem.wr_addr = piv_pos_ff;
               mem.wr_data = rd_data;
               state_in    = ST_SWAP;
            end else begin
               mem.rd_en   = 1'b1;
               mem.rd_addr = ptr_ff - ADDR_W'(1);
               ptr_in      = ptr_ff - ADDR_W'(1);
            end
         end

         // finish the swap, then reverse the suffix
         ST_SWAP: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = ptr_ff;
            mem.wr_data = pivot_ff;
            lo_in       = piv_pos_ff + ADDR_W'(1);
            hi_in       = last_pos;
            if ((CNT_W'(piv_pos_ff) + CNT_W'(2)) < count) begin
               state_in = ST_REV_LO;
            end else begin
               state_in = ST_RESULT;
            end
         end

         ST_REV_LO: begin
            mem.rd_en   = 1'b1;
            mem.rd_addr = lo_ff;
            state_in    = ST_REV_HI;
         end

         ST_REV_HI: begin
            mem.rd_en   = 1'b1;
            mem.rd_addr = hi_ff;
            hold_in     = rd_data;
            state_in    = ST_REV_WLO;
         end

         ST_REV_WLO: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = lo_ff;
            mem.wr_data = rd_data;
            state_in    = ST_REV_WHI;
         end

         // write the high end; read the next low end when pairs remain
         ST_REV_WHI: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = hi_ff;
            mem.wr_data = hold_ff;
            lo_in       = lo_ff + ADDR_W'(1);
            hi_in       = hi_ff - ADDR_W'(1);
            if ((CNT_W'(lo_ff) + CNT_W'(2)) < CNT_W'(hi_ff)) begin
               mem.rd_en   = 1'b1;
               mem.rd_addr = lo_ff + ADDR_W'(1);
               state_in    = ST_REV_HI;
            end else begin
               state_in = ST_RESULT;
            end
         end

         ST_RESULT: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ptr_ff      <= ptr_in;
      piv_pos_ff  <= piv_pos_in;
      pivot_ff    <= pivot_in;
      prev_ff     <= prev_in;
      first_ff    <= first_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      hold_ff     <= hold_in;
      res_key_ff  <= res_key_in;
      res_last_ff <= res_last_in;
   end

   assign idle         = (state_ff == ST_IDLE);
   assign res.valid    = (state_ff == ST_RESULT);
   assign res.key_out  = res_key_ff;
   assign res.was_last = res_last_ff;

endmodule

@@ verif/next_permutation_engine_top_test.sv @@
// Self-checking stream testbench for the next-permutation engine: directed cases, then random runs.
module next_permutation_engine_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import npe_pkg::*;

   // spare command code, the block answers it with a zero word
   localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

   localparam int IDLE_PCT     = 37;
   localparam int ITEM_GOAL    = 1400;
   localparam int STALL_LIMIT  = 3000;   // cycles with no word moving on either side
   localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
   localparam int DRAIN_CYCLES = 150;    // longer than the slowest advance

   typedef struct packed {
      logic [KEY_OUT_W-1:0] key_out;
      logic                 was_last;
   } rsp_word_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             csr_we     = 1'b0;
   logic [CFG_W-1:0] csr_wdata  = '0;
   logic             req_tvalid = 1'b0;
   logic [15:0]      req_tdata  = '0;
   logic [1:0]       req_tuser  = '0;
   logic             rsp_tready = 1'b0;
   wire              req_tready;
   wire              rsp_tvalid;
   wire  [7:0]       rsp_tdata;
   wire              rsp_tlast;

   // shadow copy of the key store and the item count
   logic [KEY_WIDTH-1:0] perm_keys [MAX_ITEMS];
   logic [CFG_W-1:0]     perm_count = '0;

   rsp_word_type due_words [$];

   int   errors      = 0;
   int   items_sent  = 0;
   int   stall_count = 0;
   int   src_idle    = IDLE_PCT;
   int   sink_idle   = IDLE_PCT;
   int   hold_left   = 0;
   logic hold_flip   = 1'b0;
   logic hold_seen   = 1'b0;

   always #2 clock = ~clock;

   next_permutation_engine_top DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Step the shadow keys to the next distinct arrangement; 0 when none exists.
   function automatic bit step_arrangement();
      int p, n, best, i, j;
      logic [KEY_WIDTH-1:0] t;
      n = (perm_count > MAX_ITEMS) ? MAX_ITEMS : int'(perm_count);
      if (n < 2) return 1'b0;
      // rightmost strict ascent
      p = n - 1;
      while (p > 0 && perm_keys[p-1] >= perm_keys[p]) p--;
      if (p == 0) return 1'b0;
      p--;
      // leftmost smallest key to the right that is larger than the pivot
      best = p + 1;
      for (i = p + 2; i < n; i++) begin
         if (perm_keys[i] > perm_keys[p] && perm_keys[i] < perm_keys[best]) best = i;
      end
      t               = perm_keys[p];
      perm_keys[p]    = perm_keys[best];
      perm_keys[best] = t;
      // insertion sort of the suffix, ascending
      for (i = p + 2; i < n; i++) begin
         t = perm_keys[i];
         j = i - 1;
         while (j > p && perm_keys[j] > t) begin
            perm_keys[j+1] = perm_keys[j];
            j--;
         end
         perm_keys[j+1] = t;
      end
      return 1'b1;
   endfunction

   // Expected result word of one command, shadow state updated.
   function automatic rsp_word_type engine_response(input logic [CMD_W-1:0]    cmd,
                                                    input logic [INDEX_W-1:0]  idx,
                                                    input logic [KEY_IN_W-1:0] key);
      rsp_word_type r;
      r = '0;
      case (cmd)
         CMD_LOAD: begin
            perm_keys[idx] = key;
         end
         CMD_ADVANCE: begin
            r.was_last = !step_arrangement();
         end
         CMD_READ: begin
            r.key_out = perm_keys[idx];
         end
         default: ;
      endcase
      return r;
   endfunction

   // Offer one command word, with random idle cycles ahead of it.
   task automatic send_word(input logic [CMD_W-1:0]    cmd,
                            input logic [INDEX_W-1:0]  idx,
                            input logic [KEY_IN_W-1:0] key);
      rsp_word_type want;
      want = engine_response(cmd, idx, key);
      while ($urandom_range(99) < src_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, key, idx};
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      due_words.push_back(want);
      if (cmd != CMD_NONE) items_sent++;
   endtask

   // Stop offering and wait for every due result word.
   task automatic stop_and_drain();
      req_tvalid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
   endtask

   // Item count write, only with the block idle.
   task automatic set_count(input logic [CFG_W-1:0] value);
      stop_and_drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we     <= 1'b0;
      perm_count  = value;
   endtask

   // One run: pick a count, load the keys in use, then mostly advances.
   task automatic run_phase(input int step_lo, input int step_hi);
      int roll, n, eff, steps, i;
      logic [KEY_IN_W-1:0]  span, k;
      logic [INDEX_W-1:0]   ix;
      roll = $urandom_range(99);
      if (roll < 70)      n = $urandom_range(6, 2);
      else if (roll < 85) n = $urandom_range(12, 7);
      else if (roll < 90) n = $urandom_range(1, 0);
      else if (roll < 95) n = MAX_ITEMS;
      else                n = $urandom_range(63, MAX_ITEMS + 1);
      eff = (n > MAX_ITEMS) ? MAX_ITEMS : n;
      set_count(n[CFG_W-1:0]);
      // narrow key span gives repeated keys and short cycles to the last arrangement
      span = ($urandom_range(1) == 1) ? 8'hFF : 8'h03;
      for (i = 0; i < eff; i++) begin
         k  = KEY_IN_W'($urandom_range(span));
         ix = INDEX_W'(i);
         send_word(CMD_LOAD, ix, k);
      end
      steps = (eff > 12) ? $urandom_range(8, 3) : $urandom_range(step_hi, step_lo);
      repeat (steps) begin
         roll = $urandom_range(99);
         k    = KEY_IN_W'($urandom_range(255));
         ix   = INDEX_W'($urandom_range(MAX_ITEMS - 1));
         if (roll < 75)      send_word(CMD_ADVANCE, ix, k);
         else if (roll < 88) send_word(CMD_READ, ix, k);
         else if (roll < 94) send_word(CMD_LOAD, ix, k);   // breaks the sequence
         else                send_word(CMD_NONE, ix, k);
      end
   endtask

   // count 0 after reset, spare command
   task automatic test_reset_state();
      send_word(CMD_ADVANCE, 5'd0, 8'h00);
      send_word(CMD_NONE, 5'd31, 8'hFF);
   endtask

   // field extremes on load and read
   task automatic test_load_read();
      send_word(CMD_LOAD, 5'd0, 8'h00);
      send_word(CMD_LOAD, 5'd31, 8'hFF);
      send_word(CMD_LOAD, 5'd1, 8'hAA);
      send_word(CMD_LOAD, 5'd2, 8'h55);
      send_word(CMD_READ, 5'd31, 8'h00);
      send_word(CMD_READ, 5'd0, 8'hFF);
   endtask

   // fewer than two items, then a short permutation
   task automatic test_small_counts();
      set_count(6'd1);
      send_word(CMD_ADVANCE, 5'd0, 8'h00);
      set_count(6'd3);
      send_word(CMD_ADVANCE, 5'd0, 8'h00);
      send_word(CMD_ADVANCE, 5'd0, 8'h00);
      send_word(CMD_READ, 5'd1, 8'h00);
   endtask

   // equal keys never form an ascent
   task automatic test_repeated_keys();
      send_word(CMD_LOAD, 5'd0, 8'd3);
      send_word(CMD_LOAD, 5'd1, 8'd7);
      send_word(CMD_LOAD, 5'd2, 8'd7);
      repeat (3) send_word(CMD_ADVANCE, 5'd0, 8'h00);
   endtask

   // descending keys: no successor, store unchanged
   task automatic test_last_arrangement();
      set_count(6'd2);
      send_word(CMD_LOAD, 5'd0, 8'd9);
      send_word(CMD_LOAD, 5'd1, 8'd4);
      send_word(CMD_ADVANCE, 5'd0, 8'h00);
      send_word(CMD_READ, 5'd0, 8'h00);
   endtask

   // whole store in use, then counts above the store size
   task automatic test_full_store();
      int i;
      logic [KEY_IN_W-1:0] k;
      logic [INDEX_W-1:0]  ix;
      set_count(6'd32);
      for (i = 0; i < MAX_ITEMS; i++) begin
         k  = KEY_IN_W'($urandom_range(255));
         ix = INDEX_W'(i);
         send_word(CMD_LOAD, ix, k);
      end
      repeat (3) send_word(CMD_ADVANCE, 5'd0, 8'h00);
      send_word(CMD_READ, 5'd30, 8'h00);
      send_word(CMD_READ, 5'd31, 8'h00);
      set_count(6'd63);
      repeat (2) send_word(CMD_ADVANCE, 5'd0, 8'h00);
      set_count(6'd40);
      send_word(CMD_ADVANCE, 5'd0, 8'h00);
      send_word(CMD_READ, 5'd15, 8'h00);
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      int i;
      logic [INDEX_W-1:0] ix;
      set_count(6'd4);
      for (i = 0; i < 4; i++) begin
         ix = INDEX_W'(i);
         send_word(CMD_LOAD, ix, 8'(i * 37));
      end
      hold_flip <= ~hold_flip;
      repeat (24) begin
         ix = INDEX_W'($urandom_range(3));
         if ($urandom_range(1) == 1) send_word(CMD_ADVANCE, ix, 8'h00);
         else                        send_word(CMD_READ, ix, 8'h00);
      end
   endtask

   // back to back on both sides
   task automatic test_no_idle();
      src_idle  = 0;
      sink_idle = 0;
      repeat (4) run_phase(30, 50);
      stop_and_drain();
      src_idle  = IDLE_PCT;
      sink_idle = IDLE_PCT;
   endtask

   task automatic test_random_runs();
      while (items_sent < ITEM_GOAL) run_phase(10, 40);
   endtask

   // result side: check each word, then pick the next ready level
   always @(posedge clock) begin : result_sink
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual key_out %02h was_last %0b",
                     $time, rsp_tdata, rsp_tlast);
         end else begin
            want = due_words.pop_front();
            if (rsp_tdata !== want.key_out) begin
               errors++;
               $display("%0t: key_out mismatch, expected %02h actual %02h",
                        $time, want.key_out, rsp_tdata);
            end
            if (rsp_tlast !== want.was_last) begin
               errors++;
               $display("%0t: was_last mismatch, expected %0b actual %0b",
                        $time, want.was_last, rsp_tlast);
            end
         end
      end
      if (hold_flip != hold_seen) begin
         hold_seen = hold_flip;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= sink_idle);
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_count = 0;
      else stall_count++;
      if (stall_count >= STALL_LIMIT) begin
         $display("next_permutation_engine_top_test: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_load_read();
      test_small_counts();
      test_repeated_keys();
      test_last_arrangement();
      test_full_store();
      test_backpressure();
      test_no_idle();
      test_random_runs();
      stop_and_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && due_words.size() == 0) begin
         $display("next_permutation_engine_top_test: PASS");
      end else begin
         $display("next_permutation_engine_top_test: FAIL");
      end
      $finish;
   end

endmodule
